[rtl/cau_pkg.sv]
// Package for the complex arithmetic unit: word format, opcodes, status codes
// and the packed item types of the command and result channels.
// Depends on nothing.
package cau_pkg;

  // Fixed-point word format (two's complement, Q16.16).
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Opcodes carried in the func field.
  localparam logic [3:0] FN_ADD    = 4'd0;
  localparam logic [3:0] FN_SUB    = 4'd1;
  localparam logic [3:0] FN_MUL    = 4'd2;
  localparam logic [3:0] FN_DIV    = 4'd3;
  localparam logic [3:0] FN_EQ     = 4'd4;
  localparam logic [3:0] FN_NE     = 4'd5;
  localparam logic [3:0] FN_NEG    = 4'd6;
  localparam logic [3:0] FN_NORMSQ = 4'd7;
  localparam logic [3:0] FN_DOUBLE = 4'd8;
  localparam logic [3:0] FN_MAG    = 4'd9;
  localparam logic [3:0] FN_SIGN   = 4'd10;

  // Result status codes.
  localparam logic [1:0] ST_COMPLEX = 2'd0;
  localparam logic [1:0] ST_SCALAR  = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_UNDEF   = 2'd3;

  typedef struct packed {
    logic [3:0]                  func;
    logic signed [WORD_BITS-1:0] a_real;
    logic signed [WORD_BITS-1:0] a_imag;
    logic signed [WORD_BITS-1:0] b_real;
    logic signed [WORD_BITS-1:0] b_imag;
  } cau_cmd_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] z_real;
    logic signed [WORD_BITS-1:0] z_imag;
    logic [1:0]                  status;
    logic                        saturated;
  } cau_result_t;

endpackage

[rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit: pipelined add, subtract, multiply, divide, compare
// and unary operations on Q16.16 complex operands.
// Depends on cau_pkg for the word format, opcodes and item types.
//
// Usage: the command channel (cmd_valid, cmd_ready, cmd) carries one item per
// operation, and the result channel (result_valid, result_ready, result)
// returns exactly one item for each, in order. An item can be taken in every
// cycle in which the receiver does not stall, one item per clock sustained.
// The pipeline has one stage of multipliers, one of sums, one of truncation
// and divider set-up, WORD_BITS + 1 stages of restoring division with the
// square root running alongside, one root bit a stage in all but the last,
// and the result register. It is this long because the Q16.16 quotient is
// resolved one bit per stage.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and cmd_ready falls; nothing is lost or repeated. Once result_ready
// returns, items flow again in the same cycle.
// Reset (rst, synchronous, active high) empties the pipeline by clearing the
// valid bits; the data registers are not reset.
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cau_cmd_t    cmd,
  output logic        result_valid,
  input  logic        result_ready,
  output cau_result_t result
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int SW  = 2 * W + 2;   // saturation input width
  localparam int CW  = 3 * W + 1;   // divider remainder width
  localparam int NIT = W + 1;       // quotient bits, one per stage

  localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_MUL,
    KIND_NORM,
    KIND_DIV,
    KIND_MAG
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    cau_result_t res;
    logic        neg_r;
    logic        neg_i;
    logic        ovf_r;
    logic        ovf_i;
    logic [CW-1:0] rem_r;
    logic [CW-1:0] rem_i;
    logic [W:0]    q_r;
    logic [W:0]    q_i;
    logic [2*W-1:0] d;
    logic [2*W-1:0] srem;
    logic [W-1:0]   root;
  } it_t;

  // Clip a wide signed value to the word range; returns {clipped, word}.
  function automatic logic [W:0] sat_to_word(input logic signed [SW-1:0] v);
    logic [W:0] r;
    if (v > MAXV) begin
      r = {1'b1, MAXV[W-1:0]};
    end else if (v < MINV) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  // Signed quotient from magnitude, sign and overflow; returns {clipped, word}.
  function automatic logic [W:0] div_to_word(input logic neg, input logic ovf,
                                             input logic [W:0] q);
    logic [W:0] lim;
    logic [W:0] m;
    logic       s;
    lim = neg ? LIM_NEG : LIM_POS;
    s   = ovf || (q > lim);
    m   = s ? lim : q;
    m   = neg ? (~m + 1'b1) : m;
    return {s, m[W-1:0]};
  endfunction

  logic adv;
  assign adv       = !result_valid || result_ready;
  assign cmd_ready = adv;

  // ---------------------------------------------------------------------
  // Stage A: simple operations, decode and the eight products.
  // ---------------------------------------------------------------------
  logic signed [SW-1:0] arx, aix, brx, bix;
  logic                 sr, si;
  cau_result_t          sa_res_next;
  kind_t                sa_kind_next;

  assign arx = SW'(cmd.a_real);
  assign aix = SW'(cmd.a_imag);
  assign brx = SW'(cmd.b_real);
  assign bix = SW'(cmd.b_imag);

  always_comb begin
    sa_res_next        = '0;
    sa_res_next.status = ST_UNDEF;
    sa_kind_next       = KIND_PLAIN;
    sr                 = 1'b0;
    si                 = 1'b0;
    unique case (cmd.func)
      FN_ADD: begin
        {sr, sa_res_next.z_real} = sat_to_word(arx + brx);
        {si, sa_res_next.z_imag} = sat_to_word(aix + bix);
        sa_res_next.status = ST_COMPLEX;
      end
      FN_SUB: begin
        {sr, sa_res_next.z_real} = sat_to_word(arx - brx);
        {si, sa_res_next.z_imag} = sat_to_word(aix - bix);
        sa_res_next.status = ST_COMPLEX;
      end
      FN_MUL: begin
        sa_res_next.status = ST_COMPLEX;
        sa_kind_next       = KIND_MUL;
      end
      FN_DIV: begin
        if (cmd.b_real == '0 && cmd.b_imag == '0) begin
          sa_res_next.status = ST_DIVZERO;
        end else begin
          sa_res_next.status = ST_COMPLEX;
          sa_kind_next       = KIND_DIV;
        end
      end
      FN_EQ: begin
        sa_res_next.z_real = W'(cmd.a_real == cmd.b_real && cmd.a_imag == cmd.b_imag);
        sa_res_next.status = ST_SCALAR;
      end
      FN_NE: begin
        sa_res_next.z_real = W'(cmd.a_real != cmd.b_real || cmd.a_imag != cmd.b_imag);
        sa_res_next.status = ST_SCALAR;
      end
      FN_NEG: begin
        {sr, sa_res_next.z_real} = sat_to_word(-arx);
        {si, sa_res_next.z_imag} = sat_to_word(-aix);
        sa_res_next.status = ST_COMPLEX;
      end
      FN_NORMSQ: begin
        sa_res_next.status = ST_SCALAR;
        sa_kind_next       = KIND_NORM;
      end
      FN_DOUBLE: begin
        {sr, sa_res_next.z_real} = sat_to_word(arx + arx);
        {si, sa_res_next.z_imag} = sat_to_word(aix + aix);
        sa_res_next.status = ST_COMPLEX;
      end
      FN_MAG: begin
        sa_res_next.status = ST_SCALAR;
        sa_kind_next       = KIND_MAG;
      end
      FN_SIGN: begin
        if (cmd.a_imag == '0) begin
          sa_res_next.z_real = '0;
        end else if (cmd.a_imag[W-1]) begin
          sa_res_next.z_real = '1;
        end else begin
          sa_res_next.z_real = W'(1);
        end
        sa_res_next.status = ST_SCALAR;
      end
      default: begin
        sa_res_next.status = ST_UNDEF;
      end
    endcase
    sa_res_next.saturated = sr | si;
  end

  logic                  sa_vld;
  cau_result_t           sa_res;
  kind_t                 sa_kind;
  logic signed [2*W-1:0] sa_prr, sa_pii, sa_pir, sa_pri, sa_paa, sa_pjj, sa_pbb, sa_pcc;

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_res  <= sa_res_next;
      sa_kind <= sa_kind_next;
      sa_prr  <= cmd.a_real * cmd.b_real;
      sa_pii  <= cmd.a_imag * cmd.b_imag;
      sa_pir  <= cmd.a_imag * cmd.b_real;
      sa_pri  <= cmd.a_real * cmd.b_imag;
      sa_paa  <= cmd.a_real * cmd.a_real;
      sa_pjj  <= cmd.a_imag * cmd.a_imag;
      sa_pbb  <= cmd.b_real * cmd.b_real;
      sa_pcc  <= cmd.b_imag * cmd.b_imag;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: product sums for multiply, divide, norm and divisor.
  // ---------------------------------------------------------------------
  logic                sb_vld;
  cau_result_t         sb_res;
  kind_t               sb_kind;
  logic signed [2*W:0] sb_mr, sb_mi, sb_nr, sb_ni;
  logic [2*W-1:0]      sb_d, sb_ns;

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_res  <= sa_res;
      sb_kind <= sa_kind;
      sb_mr   <= (2*W+1)'(sa_prr) - (2*W+1)'(sa_pii);
      sb_mi   <= (2*W+1)'(sa_pir) + (2*W+1)'(sa_pri);
      sb_nr   <= (2*W+1)'(sa_prr) + (2*W+1)'(sa_pii);
      sb_ni   <= (2*W+1)'(sa_pir) - (2*W+1)'(sa_pri);
      sb_d    <= sa_pbb + sa_pcc;
      sb_ns   <= sa_paa + sa_pjj;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: truncation of multiply and norm, divider and root set-up.
  // ---------------------------------------------------------------------
  it_t             pipe [0:NIT];
  logic [NIT:0]    pipe_vld;
  it_t             pipe0_next;
  logic [2*W:0]    abs_nr, abs_ni;
  logic [CW-1:0]   dtop;
  logic            mr_s, mi_s, ns_s;
  logic [W-1:0]    mr_w, mi_w, ns_w;

  assign abs_nr = sb_nr[2*W] ? -sb_nr : sb_nr;
  assign abs_ni = sb_ni[2*W] ? -sb_ni : sb_ni;
  assign dtop   = CW'(sb_d) << (W + 1);

  always_comb begin
    {mr_s, mr_w} = sat_to_word(SW'(sb_mr >>> F));
    {mi_s, mi_w} = sat_to_word(SW'(sb_mi >>> F));
    {ns_s, ns_w} = sat_to_word($signed({2'b00, sb_ns >> F}));
    pipe0_next       = '0;
    pipe0_next.kind  = sb_kind;
    pipe0_next.res   = sb_res;
    if (sb_kind == KIND_MUL) begin
      pipe0_next.res.z_real    = mr_w;
      pipe0_next.res.z_imag    = mi_w;
      pipe0_next.res.saturated = mr_s | mi_s;
    end else if (sb_kind == KIND_NORM) begin
      pipe0_next.res.z_real    = ns_w;
      pipe0_next.res.saturated = ns_s;
    end
    pipe0_next.neg_r = sb_nr[2*W];
    pipe0_next.neg_i = sb_ni[2*W];
    pipe0_next.rem_r = CW'(abs_nr[2*W-1:0]) << F;
    pipe0_next.rem_i = CW'(abs_ni[2*W-1:0]) << F;
    pipe0_next.ovf_r = pipe0_next.rem_r >= dtop;
    pipe0_next.ovf_i = pipe0_next.rem_i >= dtop;
    pipe0_next.d     = sb_d;
    pipe0_next.srem  = sb_ns;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= pipe0_next;
    end
  end

  // ---------------------------------------------------------------------
  // Iteration stages: one quotient bit for each part and, in all but the last, one root bit.
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < NIT; j++) begin : g_iter
    localparam int QB = W - j;
    localparam int RB = (j < W) ? (W - 1 - j) : 0;
    it_t           nxt;
    logic [CW-1:0] dsh;

    assign dsh = CW'(pipe[j].d) << QB;

    always_comb begin
      nxt = pipe[j];
      if (pipe[j].rem_r >= dsh) begin
        nxt.rem_r    = pipe[j].rem_r - dsh;
        nxt.q_r[QB]  = 1'b1;
      end
      if (pipe[j].rem_i >= dsh) begin
        nxt.rem_i    = pipe[j].rem_i - dsh;
        nxt.q_i[QB]  = 1'b1;
      end
      if (j < W) begin
        // Root bit RB: try (root + 2^RB)^2 - root^2 against the remainder.
        if ({1'b0, pipe[j].srem} >=
            (((2*W+1)'(pipe[j].root) << (RB + 1)) + ((2*W+1)'(1) << (2*RB)))) begin
          nxt.srem = pipe[j].srem -
            (2*W)'(((2*W+1)'(pipe[j].root) << (RB + 1)) + ((2*W+1)'(1) << (2*RB)));
          nxt.root[RB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[j+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: final quotient and root words, result register.
  // ---------------------------------------------------------------------
  cau_result_t result_next;
  logic        qr_s, qi_s;
  logic [W-1:0] qr_w, qi_w;

  always_comb begin
    {qr_s, qr_w} = div_to_word(pipe[NIT].neg_r, pipe[NIT].ovf_r, pipe[NIT].q_r);
    {qi_s, qi_w} = div_to_word(pipe[NIT].neg_i, pipe[NIT].ovf_i, pipe[NIT].q_i);
    result_next  = pipe[NIT].res;
    if (pipe[NIT].kind == KIND_DIV) begin
      result_next.z_real    = qr_w;
      result_next.z_imag    = qi_w;
      result_next.saturated = qr_s | qi_s;
    end else if (pipe[NIT].kind == KIND_MAG) begin
      result_next.z_real    = pipe[NIT].root[W-1] ? LIM_POS[W-1:0] : pipe[NIT].root;
      result_next.saturated = pipe[NIT].root[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

  // Valid bits travel with the items and freeze while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      sa_vld       <= 1'b0;
      sb_vld       <= 1'b0;
      pipe_vld     <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      sa_vld       <= cmd_valid;
      sb_vld       <= sa_vld;
      pipe_vld     <= {pipe_vld[NIT-1:0], sb_vld};
      result_valid <= pipe_vld[NIT];
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |=> $stable(pipe_vld) && $stable(sb_vld) && $stable(sa_vld))
    else $error("pipeline moved while the receiver stalled");

  a_divzero_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_DIVZERO |->
      result.z_real == '0 && result.z_imag == '0 && !result.saturated)
    else $error("divide-by-zero item carries data");

  a_undef_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_UNDEF |->
      result.z_real == '0 && result.z_imag == '0 && !result.saturated)
    else $error("undefined-operation item carries data");

  a_scalar_imag: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_SCALAR |-> result.z_imag == '0)
    else $error("scalar item with non-zero imaginary part");

endmodule
